// File: rtl/core/fgcn_pkg.sv
// ----------------------------------------------------------------------------
// fgcn_pkg
// Shared types, codes and bit-counting helpers for the friend graph core.
// ----------------------------------------------------------------------------
package fgcn_pkg;

    localparam int NUM_IDS        = 64;
    localparam int ID_W           = 6;
    localparam int CNT_W          = 7;
    localparam int MAX_PEOPLE_DEF = 64;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_BEFRIEND  = 3'd1,
        OP_UNFRIEND  = 3'd2,
        OP_TEST      = 3'd3,
        OP_COUNT     = 3'd4,
        OP_MUTUAL    = 3'd5,
        OP_RECOMMEND = 3'd6,
        OP_NONE      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_SAME    = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        status_t           status;
        logic              answer_bit;
        logic [ID_W-1:0]   person_id;
        logic [ID_W-1:0]   tally;
        logic              has_item;
        logic              last;
    } res_t;

    function automatic logic [CNT_W-1:0] popcount64(input logic [NUM_IDS-1:0] v);
        logic [3:0]       byte_cnt [8];
        logic [CNT_W-1:0] total;
        for (int k = 0; k < 8; k++) begin
            byte_cnt[k] = '0;
            for (int j = 0; j < 8; j++) begin
                byte_cnt[k] = byte_cnt[k] + 4'(v[k*8+j]);
            end
        end
        total = '0;
        for (int k = 0; k < 8; k++) begin
            total = total + CNT_W'(byte_cnt[k]);
        end
        return total;
    endfunction

    // lowest set bit
    function automatic logic [ID_W-1:0] first_set(input logic [NUM_IDS-1:0] v);
        logic [ID_W-1:0] idx;
        idx = '0;
        for (int i = NUM_IDS-1; i >= 0; i--) begin
            if (v[i]) begin
                idx = ID_W'(i);
            end
        end
        return idx;
    endfunction

    // highest set bit
    function automatic logic [ID_W-1:0] top_set(input logic [NUM_IDS-1:0] v);
        logic [ID_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_IDS; i++) begin
            if (v[i]) begin
                idx = ID_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/core/fgcn_out_reg.sv
// ----------------------------------------------------------------------------
// fgcn_out_reg
// Single-entry result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module fgcn_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fgcn_pkg::res_t   push_res,
    output logic             slot_free,
    output logic             out_valid,
    input  logic             out_ready,
    output fgcn_pkg::res_t   out_res
);
    import fgcn_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && slot_free)
        begin
            res_reg <= push_res;
        end
    end

endmodule

// File: rtl/core/friend_graph_common_neighbors_core.sv
// ----------------------------------------------------------------------------
// friend_graph_common_neighbors_core
// Friend graph held as an adjacency row memory, with pair, count, mutual
// and recommendation queries run by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | op, person_a, person_b
//  out     | out_valid / out_ready| status, answer_bit, person_id, tally,
//          |                      | has_item, last
//
//  Recommend makes two passes: the first reads every adjacency row and writes
//  the mutual count of each person who is neither A nor a friend of A to the
//  count memory; the second scans the count memory once per distinct mutual
//  count, highest count first, and lists the people holding that count.
//  Reset clears the person count; a row is zeroed when its person is added.
//  Output stalls hold the sequencer; one finished result may wait in the
//  output register while the next item is taken.
// ----------------------------------------------------------------------------
module friend_graph_common_neighbors_core #(
    parameter int MAX_PEOPLE = fgcn_pkg::MAX_PEOPLE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] op,
    input  logic [5:0] person_a,
    input  logic [5:0] person_b,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic       answer_bit,
    output logic [5:0] person_id,
    output logic [5:0] tally,
    output logic       has_item,
    output logic       last
);
    import fgcn_pkg::*;

    localparam int AW = $clog2(MAX_PEOPLE);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DEC   = 11'b000_0000_0010,
        S_RA    = 11'b000_0000_0100,
        S_RB    = 11'b000_0000_1000,
        S_MLIST = 11'b000_0001_0000,
        S_P1RD  = 11'b000_0010_0000,
        S_P1CK  = 11'b000_0100_0000,
        S_P2SEL = 11'b000_1000_0000,
        S_P2RD  = 11'b001_0000_0000,
        S_P2CK  = 11'b010_0000_0000,
        S_PUSH  = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [ID_W-1:0]      a_reg, a_next, b_reg, b_next;
    logic [CNT_W-1:0]     pc_reg, pc_next;
    logic [NUM_IDS-1:0]   row_a_reg, row_a_next;
    logic [NUM_IDS-1:0]   work_reg, work_next;
    logic [NUM_IDS-1:0]   present_reg, present_next;
    logic [ID_W-1:0]      idx_reg, idx_next;
    logic [ID_W-1:0]      num_reg, num_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    res_t                 res_reg, res_next;

    logic [NUM_IDS-1:0]   adj_mem [MAX_PEOPLE];
    logic [NUM_IDS-1:0]   adj_rd_reg;
    logic                 adj_rd_en, adj_wr_en;
    logic [AW-1:0]        adj_rd_addr, adj_wr_addr;
    logic [NUM_IDS-1:0]   adj_wr_data;

    logic [ID_W-1:0]      cnt_mem [MAX_PEOPLE];
    logic [ID_W-1:0]      cnt_rd_reg;
    logic                 cnt_rd_en, cnt_wr_en;
    logic [AW-1:0]        cnt_rd_addr, cnt_wr_addr;
    logic [ID_W-1:0]      cnt_wr_data;

    logic                 push, slot_free;
    res_t                 push_res, out_res;

    logic                 pair;
    logic                 idx_end;
    logic [NUM_IDS-1:0]   bbit, abit;
    logic [CNT_W-1:0]     pop_a, pop_cand;
    res_t                 res_zero;

    assign in_ready = (state_reg == S_IDLE);
    assign pair     = (op_reg == OP_BEFRIEND) || (op_reg == OP_UNFRIEND) ||
                      (op_reg == OP_TEST) || (op_reg == OP_MUTUAL);
    assign bbit     = NUM_IDS'(1) << b_reg;
    assign abit     = NUM_IDS'(1) << a_reg;
    assign idx_end  = ((CNT_W'(idx_reg) + CNT_W'(1)) == pc_reg);
    assign pop_a    = popcount64(adj_rd_reg);
    assign pop_cand = popcount64(row_a_reg & adj_rd_reg);
    assign res_zero = '{status: ST_OK, answer_bit: 1'b0, person_id: '0, tally: '0,
                        has_item: 1'b0, last: 1'b1};

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        pc_next         = pc_reg;
        row_a_next      = row_a_reg;
        work_next       = work_reg;
        present_next    = present_reg;
        idx_next        = idx_reg;
        num_next        = num_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        res_next        = res_reg;
        adj_rd_en       = 1'b0;
        adj_rd_addr     = a_reg[AW-1:0];
        adj_wr_en       = 1'b0;
        adj_wr_addr     = a_reg[AW-1:0];
        adj_wr_data     = '0;
        cnt_rd_en       = 1'b0;
        cnt_rd_addr     = idx_reg[AW-1:0];
        cnt_wr_en       = 1'b0;
        cnt_wr_addr     = idx_reg[AW-1:0];
        cnt_wr_data     = '0;
        push            = 1'b0;
        push_res        = res_zero;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op_t'(op);
                    a_next     = person_a;
                    b_next     = person_b;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_next   = res_zero;
                state_next = S_PUSH;
                if (op_reg == OP_NONE)
                begin
                    res_next = res_zero;
                end
                else if (op_reg == OP_ADD)
                begin
                    if (pc_reg >= CNT_W'(MAX_PEOPLE))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        adj_wr_en          = 1'b1;
                        adj_wr_addr        = pc_reg[AW-1:0];
                        adj_wr_data        = '0;
                        res_next.person_id = pc_reg[ID_W-1:0];
                        pc_next            = pc_reg + CNT_W'(1);
                    end
                end
                else if ((CNT_W'(a_reg) >= pc_reg) || (pair && (CNT_W'(b_reg) >= pc_reg)))
                begin
                    res_next.status = ST_UNKNOWN;
                end
                else if (pair && (a_reg == b_reg))
                begin
                    res_next.status = ST_SAME;
                end
                else
                begin
                    adj_rd_en  = 1'b1;
                    adj_rd_addr = a_reg[AW-1:0];
                    state_next = S_RA;
                end
            end
            S_RA:
            begin
                row_a_next = adj_rd_reg;
                res_next   = res_zero;
                state_next = S_PUSH;
                case (op_reg)
                    OP_BEFRIEND:
                    begin
                        if ((adj_rd_reg & bbit) == '0)
                        begin
                            adj_wr_en   = 1'b1;
                            adj_wr_data = adj_rd_reg | bbit;
                            adj_rd_en   = 1'b1;
                            adj_rd_addr = b_reg[AW-1:0];
                            state_next  = S_RB;
                        end
                    end
                    OP_UNFRIEND:
                    begin
                        if ((adj_rd_reg & bbit) != '0)
                        begin
                            adj_wr_en   = 1'b1;
                            adj_wr_data = adj_rd_reg & ~bbit;
                            adj_rd_en   = 1'b1;
                            adj_rd_addr = b_reg[AW-1:0];
                            state_next  = S_RB;
                        end
                    end
                    OP_TEST:
                    begin
                        res_next.answer_bit = ((adj_rd_reg & bbit) != '0);
                    end
                    OP_COUNT:
                    begin
                        res_next.tally = pop_a[ID_W-1:0];
                    end
                    OP_MUTUAL:
                    begin
                        adj_rd_en   = 1'b1;
                        adj_rd_addr = b_reg[AW-1:0];
                        state_next  = S_RB;
                    end
                    default:
                    begin
                        idx_next        = '0;
                        present_next    = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_P1RD;
                    end
                endcase
            end
            S_RB:
            begin
                res_next            = res_zero;
                res_next.answer_bit = 1'b1;
                adj_wr_addr         = b_reg[AW-1:0];
                state_next          = S_PUSH;
                if (op_reg == OP_BEFRIEND)
                begin
                    adj_wr_en   = 1'b1;
                    adj_wr_data = adj_rd_reg | abit;
                end
                else if (op_reg == OP_UNFRIEND)
                begin
                    adj_wr_en   = 1'b1;
                    adj_wr_data = adj_rd_reg & ~abit;
                end
                else
                begin
                    work_next  = row_a_reg & adj_rd_reg;
                    state_next = S_MLIST;
                end
            end
            S_MLIST:
            begin
                if (work_reg == '0)
                begin
                    res_next   = res_zero;
                    state_next = S_PUSH;
                end
                else if (slot_free)
                begin
                    push               = 1'b1;
                    push_res           = res_zero;
                    push_res.person_id = first_set(work_reg);
                    push_res.has_item  = 1'b1;
                    push_res.last      = ((work_reg & (work_reg - NUM_IDS'(1))) == '0);
                    work_next          = work_reg & (work_reg - NUM_IDS'(1));
                    if (push_res.last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_P1RD:
            begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = idx_reg[AW-1:0];
                state_next  = S_P1CK;
            end
            S_P1CK:
            begin
                cnt_wr_en = 1'b1;
                if ((idx_reg != a_reg) && !row_a_reg[idx_reg])
                begin
                    cnt_wr_data = pop_cand[ID_W-1:0];
                    if (pop_cand[ID_W-1:0] != '0)
                    begin
                        present_next[pop_cand[ID_W-1:0]] = 1'b1;
                    end
                end
                idx_next   = idx_reg + ID_W'(1);
                state_next = idx_end ? S_P2SEL : S_P1RD;
            end
            S_P2SEL:
            begin
                if (present_reg == '0)
                begin
                    res_next = res_zero;
                    if (pend_valid_reg)
                    begin
                        res_next.person_id = pend_id_reg;
                        res_next.tally     = num_reg;
                        res_next.has_item  = 1'b1;
                    end
                    state_next = S_PUSH;
                end
                else
                begin
                    if (!pend_valid_reg)
                    begin
                        num_next = top_set(present_reg);
                        present_next[top_set(present_reg)] = 1'b0;
                        idx_next   = '0;
                        state_next = S_P2RD;
                    end
                    else if (slot_free)
                    begin
                        // flush the held entry before moving to a lower count
                        push               = 1'b1;
                        push_res           = res_zero;
                        push_res.person_id = pend_id_reg;
                        push_res.tally     = num_reg;
                        push_res.has_item  = 1'b1;
                        push_res.last      = 1'b0;
                        pend_valid_next    = 1'b0;
                    end
                end
            end
            S_P2RD:
            begin
                cnt_rd_en  = 1'b1;
                state_next = S_P2CK;
            end
            S_P2CK:
            begin
                if (cnt_rd_reg != num_reg)
                begin
                    idx_next   = idx_reg + ID_W'(1);
                    state_next = idx_end ? S_P2SEL : S_P2RD;
                end
                else if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        push               = 1'b1;
                        push_res           = res_zero;
                        push_res.person_id = pend_id_reg;
                        push_res.tally     = num_reg;
                        push_res.has_item  = 1'b1;
                        push_res.last      = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = idx_reg;
                    idx_next        = idx_reg + ID_W'(1);
                    state_next      = idx_end ? S_P2SEL : S_P2RD;
                end
            end
            S_PUSH:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    push_res   = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pc_reg         <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        row_a_reg   <= row_a_next;
        work_reg    <= work_next;
        present_reg <= present_next;
        idx_reg     <= idx_next;
        num_reg     <= num_next;
        pend_id_reg <= pend_id_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (adj_wr_en)
        begin
            adj_mem[adj_wr_addr] <= adj_wr_data;
        end
        if (adj_rd_en)
        begin
            adj_rd_reg <= adj_mem[adj_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_wr_en)
        begin
            cnt_mem[cnt_wr_addr] <= cnt_wr_data;
        end
        if (cnt_rd_en)
        begin
            cnt_rd_reg <= cnt_mem[cnt_rd_addr];
        end
    end

    fgcn_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status     = out_res.status;
    assign answer_bit = out_res.answer_bit;
    assign person_id  = out_res.person_id;
    assign tally      = out_res.tally;
    assign has_item   = out_res.has_item;
    assign last       = out_res.last;

endmodule

// File: rtl/core/fgcn_checker.sv
// ----------------------------------------------------------------------------
// fgcn_checker
// Port-level checks on the result channel of the friend graph core.
// ----------------------------------------------------------------------------
module fgcn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic       answer_bit,
    input logic [5:0] person_id,
    input logic [5:0] tally,
    input logic       has_item,
    input logic       last
);
    import fgcn_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(person_id) && $stable(tally) && $stable(last))
        else $error("result changed while stalled");

    a_item_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_item |-> status == ST_OK && !answer_bit)
        else $error("list entry with error or answer bit");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && !has_item && !answer_bit &&
        person_id == 6'd0 && tally == 6'd0)
        else $error("error result not a lone final transfer");

    a_answer_plain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && answer_bit |-> last && person_id == 6'd0 && tally == 6'd0)
        else $error("answer bit on a list or count result");

endmodule

bind friend_graph_common_neighbors_core fgcn_checker u_fgcn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .answer_bit (answer_bit),
    .person_id  (person_id),
    .tally      (tally),
    .has_item   (has_item),
    .last       (last)
);
